>>> src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CHK_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CHK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> src/clst_pkg.sv
// ----------------------------------------------------------------------------
// clst_pkg
// Types and constants shared by the circular log send tracker modules.
// ----------------------------------------------------------------------------
package clst_pkg;

  // Field widths.
  localparam int IDX_W       = 10;
  localparam int STAMP_W     = 64;
  localparam int OP_W        = 3;
  localparam int IN_TDATA_W  = 80;
  localparam int OUT_TDATA_W = 80;
  localparam int IN_PAD_W    = IN_TDATA_W - IDX_W - STAMP_W - 1;
  localparam int OUT_PAD_W   = OUT_TDATA_W - IDX_W - STAMP_W;

  // An all-ones stamp marks an empty slot.
  localparam logic [STAMP_W-1:0] STAMP_EMPTY = {STAMP_W{1'b1}};

  // Operation codes.
  typedef enum logic [OP_W-1:0] {
    OP_SCAN    = 3'd0,
    OP_END     = 3'd1,
    OP_WRITE   = 3'd2,
    OP_SEND    = 3'd3,
    OP_CONFIRM = 3'd4
  } op_t;

  // Controller states.
  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_EXEC = 1'b1
  } state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_in;
    logic exec;
  } dp_cmd_t;

endpackage

>>> src/circular_log_send_tracker.sv
// Each item is registered in the input register, then executed into the result register.
// A new item is taken only once the current one has executed.
// The execute cycle waits while the previous result is still held unaccepted.
// Reset (rst_n low, synchronous) empties the log pointers and clears all marks.
// No clearing pass: the block accepts items in the first cycle after reset.
// ----------------------------------------------------------------------------
// circular_log_send_tracker
// Slot pointer manager for a circular record log with send tracking.
// ----------------------------------------------------------------------------
module circular_log_send_tracker
  import clst_pkg::*;
#(
  parameter int SLOT_COUNT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // [9:0] record_index, [73:10] record_stamp, [74] record_sent, rest zero
  input  logic [IN_TDATA_W-1:0]  in_tdata,
  // [2:0] operation
  input  logic [OP_W-1:0]        in_tuser,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // [9:0] result_index, [73:10] result_stamp, rest zero
  output logic [OUT_TDATA_W-1:0] out_tdata,
  // [0] result_valid
  output logic                   out_tuser
);

  dp_cmd_t            cmd;
  logic [IDX_W-1:0]   res_idx;
  logic [STAMP_W-1:0] res_stamp;

  clst_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  clst_dp #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_op     (in_tuser),
    .in_idx    (in_tdata[IDX_W-1:0]),
    .in_stamp  (in_tdata[IDX_W+STAMP_W-1:IDX_W]),
    .in_sent   (in_tdata[IDX_W+STAMP_W]),
    .res_valid (out_tuser),
    .res_idx   (res_idx),
    .res_stamp (res_stamp)
  );

  // Pack the result fields, lowest field first.
  assign out_tdata = {{OUT_PAD_W{1'b0}}, res_stamp, res_idx};

endmodule

>>> src/clst_ctrl.sv
// ----------------------------------------------------------------------------
// clst_ctrl
// Controller: takes one item, runs it through the datapath once the output
// register is free, and owns both handshakes.
// ----------------------------------------------------------------------------
module clst_ctrl
  import clst_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_tvalid,
  output logic    in_tready,
  output logic    out_tvalid,
  input  logic    out_tready,
  output dp_cmd_t cmd
);

  state_t state_r;
  state_t state_nxt;
  logic   out_valid_r;
  logic   out_valid_nxt;
  logic   out_free;

  // The output register can take a new result when empty or being drained.
  assign out_free = !out_valid_r || out_tready;

  // Next state.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Outputs and commands.
  always_comb begin
    in_tready   = 1'b0;
    cmd.load_in = 1'b0;
    cmd.exec    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_tready   = 1'b1;
        cmd.load_in = in_tvalid;
      end
      ST_EXEC: begin
        cmd.exec = out_free;
      end
      default: begin
        in_tready = 1'b0;
      end
    endcase
  end

  // Result valid flag: set on execution, cleared once the transfer completes.
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.exec) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

>>> src/clst_dp.sv
// ----------------------------------------------------------------------------
// clst_dp
// Datapath: input register, slot pointer state and result register.
// ----------------------------------------------------------------------------
module clst_dp
  import clst_pkg::*;
#(
  parameter int SLOT_COUNT = 1024
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  dp_cmd_t                cmd,
  input  logic [OP_W-1:0]        in_op,
  input  logic [IDX_W-1:0]       in_idx,
  input  logic [STAMP_W-1:0]     in_stamp,
  input  logic                   in_sent,
  output logic                   res_valid,
  output logic [IDX_W-1:0]       res_idx,
  output logic [STAMP_W-1:0]     res_stamp
);

  // Slot registers are wide enough for both the index field and the log size.
  localparam int SLOT_W = ($clog2(SLOT_COUNT) > IDX_W) ? $clog2(SLOT_COUNT) : IDX_W;
  localparam logic [SLOT_W:0] SLOT_LIMIT = (SLOT_W + 1)'(SLOT_COUNT);

  function automatic logic [SLOT_W-1:0] wrap_inc(input logic [SLOT_W-1:0] s);
    logic [SLOT_W:0] n;
    n = {1'b0, s} + (SLOT_W + 1)'(1);
    return (n >= SLOT_LIMIT) ? '0 : n[SLOT_W-1:0];
  endfunction

  // Captured item.
  logic [OP_W-1:0]    op_r;
  logic [IDX_W-1:0]   idx_r;
  logic [STAMP_W-1:0] stamp_r;
  logic               sent_r;

  // Pointer state.
  logic               has_r,       has_nxt;
  logic [SLOT_W-1:0]  old_slot_r,  old_slot_nxt;
  logic [SLOT_W-1:0]  new_slot_r,  new_slot_nxt;
  logic [STAMP_W-1:0] old_stamp_r, old_stamp_nxt;
  logic [STAMP_W-1:0] new_stamp_r, new_stamp_nxt;
  logic               ss_r,        ss_nxt;
  logic [STAMP_W-1:0] ss_stamp_r,  ss_stamp_nxt;
  logic [SLOT_W-1:0]  ss_slot_r,   ss_slot_nxt;
  logic               ls_v_r,      ls_v_nxt;
  logic [SLOT_W-1:0]  ls_slot_r,   ls_slot_nxt;
  logic               if_v_r,      if_v_nxt;
  logic [SLOT_W-1:0]  if_slot_r,   if_slot_nxt;

  // Result register and its next value.
  logic               res_valid_r, res_valid_nxt;
  logic [SLOT_W-1:0]  res_slot_r,  res_slot_nxt;
  logic [STAMP_W-1:0] res_stamp_r, res_stamp_nxt;

  logic [SLOT_W-1:0]  idx_ext;
  logic               rec_ok;
  logic [SLOT_W-1:0]  new_inc;
  logic               drop;

  assign idx_ext = SLOT_W'(idx_r);
  assign rec_ok  = ({1'b0, idx_ext} < SLOT_LIMIT) && (stamp_r != STAMP_EMPTY);
  assign new_inc = wrap_inc(new_slot_r);
  // A write that lands on the oldest slot pushes the oldest pointer forward.
  assign drop    = has_r && (old_slot_r != new_slot_r) && (old_slot_r == new_inc);

  // Input capture.
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      op_r    <= in_op;
      idx_r   <= in_idx;
      stamp_r <= in_stamp;
      sent_r  <= in_sent;
    end
  end

  // Operation execution.
  always_comb begin
    has_nxt       = has_r;
    old_slot_nxt  = old_slot_r;
    new_slot_nxt  = new_slot_r;
    old_stamp_nxt = old_stamp_r;
    new_stamp_nxt = new_stamp_r;
    ss_nxt        = ss_r;
    ss_stamp_nxt  = ss_stamp_r;
    ss_slot_nxt   = ss_slot_r;
    ls_v_nxt      = ls_v_r;
    ls_slot_nxt   = ls_slot_r;
    if_v_nxt      = if_v_r;
    if_slot_nxt   = if_slot_r;
    res_valid_nxt = 1'b0;
    res_slot_nxt  = '0;
    res_stamp_nxt = '0;
    unique case (op_r)
      OP_SCAN: begin
        // Slot zero opens a new scan.
        if (idx_r == '0) begin
          has_nxt       = 1'b0;
          ss_nxt        = 1'b0;
          if_v_nxt      = 1'b0;
          old_stamp_nxt = STAMP_EMPTY;
          new_stamp_nxt = STAMP_EMPTY;
        end
        if (rec_ok) begin
          if (!has_nxt) begin
            has_nxt       = 1'b1;
            old_slot_nxt  = idx_ext;
            new_slot_nxt  = idx_ext;
            old_stamp_nxt = stamp_r;
            new_stamp_nxt = stamp_r;
          end else begin
            if (stamp_r < old_stamp_nxt) begin
              old_stamp_nxt = stamp_r;
              old_slot_nxt  = idx_ext;
            end
            if (stamp_r > new_stamp_nxt) begin
              new_stamp_nxt = stamp_r;
              new_slot_nxt  = idx_ext;
            end
          end
          if (sent_r && (!ss_nxt || stamp_r > ss_stamp_r)) begin
            ss_nxt       = 1'b1;
            ss_stamp_nxt = stamp_r;
            ss_slot_nxt  = idx_ext;
          end
        end
      end
      OP_END: begin
        ls_v_nxt      = ss_r;
        ls_slot_nxt   = ss_r ? ss_slot_r : '0;
        res_stamp_nxt = has_r ? new_stamp_r : STAMP_EMPTY;
      end
      OP_WRITE: begin
        if (!has_r) begin
          has_nxt      = 1'b1;
          old_slot_nxt = '0;
          new_slot_nxt = '0;
        end else begin
          new_slot_nxt = new_inc;
          if (drop) begin
            if (if_v_r && if_slot_r == old_slot_r) begin
              if_v_nxt = 1'b0;
            end
            if (ls_v_r && ls_slot_r == old_slot_r) begin
              ls_v_nxt = 1'b0;
            end
            old_slot_nxt = wrap_inc(old_slot_r);
          end
        end
        res_valid_nxt = 1'b1;
        res_slot_nxt  = new_slot_nxt;
      end
      OP_SEND: begin
        if (ls_v_r) begin
          if (ls_slot_r == new_slot_r) begin
            if_v_nxt = 1'b0;
          end else begin
            if_v_nxt    = 1'b1;
            if_slot_nxt = wrap_inc(ls_slot_r);
          end
        end else begin
          if_v_nxt    = has_r;
          if_slot_nxt = has_r ? old_slot_r : '0;
        end
        res_valid_nxt = if_v_nxt;
        res_slot_nxt  = if_v_nxt ? if_slot_nxt : '0;
      end
      OP_CONFIRM: begin
        if (if_v_r) begin
          ls_v_nxt      = 1'b1;
          ls_slot_nxt   = if_slot_r;
          res_valid_nxt = 1'b1;
          res_slot_nxt  = if_slot_r;
        end
      end
      default: begin
        res_valid_nxt = 1'b0;
      end
    endcase
  end

  // Pointer state registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      has_r       <= 1'b0;
      old_slot_r  <= '0;
      new_slot_r  <= '0;
      old_stamp_r <= STAMP_EMPTY;
      new_stamp_r <= STAMP_EMPTY;
      ss_r        <= 1'b0;
      ss_stamp_r  <= '0;
      ss_slot_r   <= '0;
      ls_v_r      <= 1'b0;
      ls_slot_r   <= '0;
      if_v_r      <= 1'b0;
      if_slot_r   <= '0;
    end else if (cmd.exec) begin
      has_r       <= has_nxt;
      old_slot_r  <= old_slot_nxt;
      new_slot_r  <= new_slot_nxt;
      old_stamp_r <= old_stamp_nxt;
      new_stamp_r <= new_stamp_nxt;
      ss_r        <= ss_nxt;
      ss_stamp_r  <= ss_stamp_nxt;
      ss_slot_r   <= ss_slot_nxt;
      ls_v_r      <= ls_v_nxt;
      ls_slot_r   <= ls_slot_nxt;
      if_v_r      <= if_v_nxt;
      if_slot_r   <= if_slot_nxt;
    end
  end

  // Result register; held until the controller runs the next item.
  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      res_valid_r <= res_valid_nxt;
      res_slot_r  <= res_slot_nxt;
      res_stamp_r <= res_stamp_nxt;
    end
  end

  assign res_valid = res_valid_r;
  assign res_idx   = res_slot_r[IDX_W-1:0];
  assign res_stamp = res_stamp_r;

endmodule

>>> src/clst_checker.sv
// ----------------------------------------------------------------------------
// clst_checker
// Port-level checks on the send tracker, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module clst_checker
  import clst_pkg::*;
(
  input logic                   clk,
  input logic                   rst_n,
  input logic                   in_tvalid,
  input logic                   in_tready,
  input logic                   out_tvalid,
  input logic                   out_tready,
  input logic [OUT_TDATA_W-1:0] out_tdata,
  input logic                   out_tuser
);

  // One item at a time: the input side closes right after a transfer.
  `CHK_NEXT(a_one_item, in_tvalid && in_tready, !in_tready, "input taken during execute")

  // A stalled result stays offered.
  `CHK_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `CHK_NEXT(a_out_stable, out_tvalid && !out_tready,
            $stable(out_tdata) && $stable(out_tuser), "result changed while stalled")

  // A result without a slot reports slot zero.
  `CHK_SAME(a_none_zero, out_tvalid && !out_tuser,
            out_tdata[IDX_W-1:0] == '0, "slot set on empty result")

endmodule

bind circular_log_send_tracker clst_checker u_clst_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);
